### hdl/rmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_pkg: shared types for the running median filter
// Sample type, register constants and the per-cell entry and link structs.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 5;
  // Ages reach at most 63 (window of 64).
  localparam int AGE_W     = 6;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]    cfg_t;
  typedef logic [AGE_W-1:0]    age_t;

  // One slot of the sorted chain.
  typedef struct packed {
    logic    valid;
    age_t    age;
    sample_t value;
  } entry_t;

  // Passed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic   del;   // oldest entry removed at or left of this cell
    logic   ins;   // insertion point at or left of this cell
    entry_t comp;  // this cell's entry after removal
  } link_t;

endpackage

### hdl/rmf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_ifs: stream channels of the running median filter
// Valid/ready channels for input samples and output medians.
// ----------------------------------------------------------------------------
interface rmf_sample_if;
  logic                 valid;
  logic                 ready;
  rmf_pkg::sample_t     sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmf_median_if;
  logic                 valid;
  logic                 ready;
  rmf_pkg::sample_t     median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

### hdl/rmf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_cell: one slot of the sorted sample chain
// Drops the oldest entry (shift from the right), then opens a gap for the
// new sample (shift from the left). Ages advance by one per step.
// ----------------------------------------------------------------------------
module rmf_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic             step,
  input  logic             full,
  input  rmf_pkg::age_t    oldest_age,
  input  rmf_pkg::sample_t sample,
  input  rmf_pkg::entry_t  right,
  input  rmf_pkg::link_t   left,
  output rmf_pkg::entry_t  q,
  output rmf_pkg::link_t   link
);
  import rmf_pkg::*;

  logic   del_here;
  logic   d;
  entry_t c;
  logic   h;
  entry_t q_next;

  always_comb begin
    del_here = full & q.valid & (q.age == oldest_age);
    d        = left.del | del_here;
    c        = d ? right : q;
    h        = ~c.valid | (c.value > sample);

    if (!h) begin
      q_next     = c;
      q_next.age = c.age + age_t'(1);
    end else if (left.ins) begin
      q_next     = left.comp;
      q_next.age = left.comp.age + age_t'(1);
    end else begin
      q_next.valid = 1'b1;
      q_next.age   = '0;
      q_next.value = sample;
    end

    link.del  = d;
    link.ins  = h;
    link.comp = c;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      q <= '0;
    end else if (step) begin
      q <= q_next;
    end
  end

endmodule

### hdl/running_median_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_filter_top: running median over the newest samples
// Sorted chain of cells with age tags, median picked from the middle.
// ----------------------------------------------------------------------------
// Usage:
//   samples : valid/ready sink, one 16-bit unsigned sample per word.
//   medians : valid/ready source, one 16-bit median per accepted sample.
//   cfg_we/cfg_data : window_size write (0 acts as 1, above WINDOW_MAX acts
//     as WINDOW_MAX). A write clears the window; issue it only when idle.
// Operation:
//   On acceptance the sample is inserted into the sorted cell chain while the
//   oldest entry (age = window - 1) drops out once full. Once the output
//   register is free, the middle cell(s) are picked and loaded into it.
// Flow control:
//   samples.ready drops while a sorted update waits for the middle-select/add
//   stage, so a new sample is taken only after the previous update has
//   loaded its median into the output register.
// Reset:
//   rst clears the chain and fill count, window_size returns to 5.
// Backpressure:
//   A stalled result holds in the output register; one more sample may be
//   taken and sorted meanwhile, further samples wait until it drains.
// ----------------------------------------------------------------------------
module running_median_filter_top #(
  parameter int WINDOW_MAX = 16   // 1..64
) (
  input  logic                clk,
  input  logic                rst,
  rmf_sample_if.sink          samples,
  rmf_median_if.source        medians,
  input  logic                cfg_we,
  input  rmf_pkg::cfg_t       cfg_data
);
  import rmf_pkg::*;

  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int RESET_N = (CFG_RESET > WINDOW_MAX) ? WINDOW_MAX : CFG_RESET;

  // Effective window size, clipped at write time.
  logic [CNT_W-1:0] win_n;
  logic [CNT_W-1:0] win_n_next;
  // Number of valid cells.
  logic [CNT_W-1:0] count;
  logic             full;
  logic             busy;
  logic             step;
  age_t             oldest_age;

  entry_t           cells_q  [WINDOW_MAX];
  entry_t           rights   [WINDOW_MAX];
  link_t            lefts    [WINDOW_MAX];
  link_t            links    [WINDOW_MAX];

  sample_t          vals     [2**IDX_W];
  logic [CNT_W-1:0] half;
  logic [IDX_W-1:0] hi_idx;
  logic [IDX_W-1:0] lo_idx;
  logic [SAMPLE_W:0] pair_sum;
  sample_t          median_next;

  logic             out_free;
  logic             out_valid;
  sample_t          out_median;

  // --- configuration ---------------------------------------------------------
  always_comb begin
    if (cfg_data == '0) begin
      win_n_next = CNT_W'(1);
    end else if (32'(cfg_data) > 32'(WINDOW_MAX)) begin
      win_n_next = CNT_W'(WINDOW_MAX);
    end else begin
      win_n_next = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_n <= CNT_W'(RESET_N);
    end else if (cfg_we) begin
      win_n <= win_n_next;
    end
  end

  // --- chain control ---------------------------------------------------------
  assign step          = samples.valid & samples.ready;
  assign samples.ready = ~busy;
  assign full          = (count == win_n);
  assign oldest_age    = AGE_W'(win_n - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      count <= '0;
    end else if (step && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  // --- cell chain ------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
      if (gi == WINDOW_MAX - 1) begin : g_last
        assign rights[gi] = '0;
      end else begin : g_mid
        assign rights[gi] = cells_q[gi+1];
      end
      if (gi == 0) begin : g_first
        assign lefts[gi] = '0;
      end else begin : g_rest
        assign lefts[gi] = links[gi-1];
      end

      rmf_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .clr        (cfg_we),
        .step       (step),
        .full       (full),
        .oldest_age (oldest_age),
        .sample     (samples.sample),
        .right      (rights[gi]),
        .left       (lefts[gi]),
        .q          (cells_q[gi]),
        .link       (links[gi])
      );
    end

    for (gi = 0; gi < 2**IDX_W; gi++) begin : g_vals
      if (gi < WINDOW_MAX) begin : g_real
        assign vals[gi] = cells_q[gi].value;
      end else begin : g_pad
        assign vals[gi] = '0;
      end
    end
  endgenerate

  // --- middle select ---------------------------------------------------------
  // Odd count: middle cell. Even count: truncated mean of the two middles.
  always_comb begin
    half        = count >> 1;
    hi_idx      = IDX_W'(half);
    lo_idx      = IDX_W'(half - CNT_W'(1));
    pair_sum    = {1'b0, vals[lo_idx]} + {1'b0, vals[hi_idx]};
    median_next = count[0] ? vals[hi_idx] : pair_sum[SAMPLE_W:1];
  end

  // --- output register -------------------------------------------------------
  assign out_free = ~out_valid | medians.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (busy && out_free) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        if (step) begin
          busy <= 1'b1;
        end
        if (medians.ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      out_median <= median_next;
    end
  end

  assign medians.valid  = out_valid;
  assign medians.median = out_median;

  // --- assertions ------------------------------------------------------------
  logic [WINDOW_MAX-1:0] valid_bits;

  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_vbits
      assign valid_bits[gi] = cells_q[gi].valid;
    end
  endgenerate

  // Occupied cells track the fill count.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    32'($countones(valid_bits)) == 32'(count))
    else $error("cell occupancy differs from fill count");

  // Fill count never passes the window.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= win_n)
    else $error("fill count above window size");

  // No new word is taken while a sorted update still waits for its median.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_free) |=> busy)
    else $error("pending update lost");

  generate
    for (gi = 0; gi < WINDOW_MAX - 1; gi++) begin : g_order
      a_sorted: assert property (@(posedge clk) disable iff (rst)
        cells_q[gi+1].valid |-> (cells_q[gi].valid &&
          cells_q[gi].value <= cells_q[gi+1].value))
        else $error("cell chain out of order");
    end
  endgenerate

endmodule

### tb/running_median_filter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_filter_top_test: self-checking bench for the median filter
// Streams samples through the block under random input gaps and output stalls,
// predicts each median from its own copy of the sample window, and compares
// every output word in order. window_size is rewritten between phases.
// ----------------------------------------------------------------------------
module running_median_filter_top_test;
  import rmf_pkg::*;

  localparam int WINDOW_MAX  = 16;
  // Cycles without any accepted word before the run is declared hung.
  localparam int QUIET_LIMIT = 400;
  // Settle time after the last median.
  localparam int SETTLE      = 4;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 65;

  // --------------------------------------------------------------------------
  // Running median tracker: own copy of the window, the fill count and the
  // window_size register, plus the queue of medians still owed by the block.
  // --------------------------------------------------------------------------
  class median_tracker;
    sample_t     held [WINDOW_MAX];
    int          fill;
    cfg_t        size_reg;
    sample_t     pending [$];
    int unsigned failures;
    int unsigned checked;

    function new();
      failures = 0;
      checked  = 0;
      restart(cfg_t'(CFG_RESET));
    endfunction

    // A window_size write (and reset) empties the window.
    function void restart(cfg_t v);
      size_reg = v;
      foreach (held[i]) held[i] = '0;
      fill = 0;
    endfunction

    // Shift in an accepted sample and queue the median it produces.
    function void note_sample(sample_t s);
      int            n;
      int            j;
      sample_t       v;
      sample_t       order [WINDOW_MAX];
      logic [16:0]   pair_sum;
      // 0 behaves as 1, anything above the chain length as the full chain
      n = int'(size_reg);
      if (n < 1) n = 1;
      if (n > WINDOW_MAX) n = WINDOW_MAX;
      for (int i = n - 1; i > 0; i--) held[i] = held[i - 1];
      held[0] = s;
      if (fill < n) fill++;
      if (fill > n) fill = n;
      // insertion sort of the held part only
      for (int i = 0; i < fill; i++) begin
        v = held[i];
        j = i;
        while (j > 0 && order[j - 1] > v) begin
          order[j] = order[j - 1];
          j--;
        end
        order[j] = v;
      end
      if (fill % 2 == 0) begin
        pair_sum = {1'b0, order[fill / 2 - 1]} + {1'b0, order[fill / 2]};
        pending.push_back(pair_sum[16:1]);
      end else begin
        pending.push_back(order[fill / 2]);
      end
    endfunction

    function void check_median(sample_t got);
      sample_t want;
      if (pending.size() == 0) begin
        fault("median word with nothing outstanding", 'x, got);
      end else begin
        want = pending.pop_front();
        checked++;
        if (got !== want) fault("median mismatch", want, got);
      end
    endfunction

    function void fault(string what, sample_t want, sample_t got);
      failures++;
      if (failures <= 10)
        $display("%0t: %s (word %0d): expected %h, got %h", $time, what, checked,
                 want, got);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the two stream channels
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;
  logic cfg_we;
  cfg_t cfg_data;

  rmf_sample_if sample_ch ();
  rmf_median_if median_ch ();

  running_median_filter_top #(
    .WINDOW_MAX (WINDOW_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_ch),
    .medians  (median_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  median_tracker tracker;

  // Traffic shaping knobs, changed per phase. calm turns all idling off.
  bit          calm;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned gap_cycles;
  int unsigned stall_cycles;
  int unsigned sent;
  int unsigned settings;

  // Random sample shapes: uniform, cluster around a base (lots of ties), extremes, ramps.
  sample_t cluster_base;
  sample_t ramp_pos;
  sample_t ramp_step;

  // --------------------------------------------------------------------------
  // Input side. Every drive happens right after a rising edge with NBAs, and
  // handshakes are read right after the edge, i.e. the pre-edge values.
  // --------------------------------------------------------------------------

  // Offer one sample word, optionally after an idle burst, and hold it until
  // the block takes it.
  task automatic push_sample(input sample_t v);
    int unsigned gap;
    if (!calm && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(5, 1);
      gap_cycles += gap;
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= v;
    do @(posedge clk); while (!sample_ch.ready);
    tracker.note_sample(v);
    sent++;
  endtask

  // Stop sending and wait until every owed median has come out.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // window_size may only change while the block is empty.
  task automatic write_window(input cfg_t v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tracker.restart(v);
    settings++;
  endtask

  function automatic sample_t draw_sample();
    sample_t s;
    case ($urandom_range(9))
      0, 1, 2, 3: s = sample_t'($urandom);
      4, 5:       s = cluster_base + sample_t'($urandom_range(7));
      6:          s = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      7:          s = $urandom_range(1) ? 16'hFFFE : 16'h0001;
      default: begin
        ramp_pos = ramp_pos + ramp_step;
        s = ramp_pos;
      end
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: check each accepted median word, stall ready in bursts.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    hold = 0;
    median_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && median_ch.valid && median_ch.ready)
        tracker.check_median(median_ch.median);
      if (hold == 0 && !calm && !rst && $urandom_range(99) < stall_pct)
        hold = $urandom_range(5, 1);
      median_ch.ready <= (hold == 0);
      if (hold > 0) begin
        hold--;
        stall_cycles++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long stretch with no word moving on either side means a hang.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_ch.valid && sample_ch.ready) ||
          (median_ch.valid && median_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no word accepted for %0d cycles", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t    window_plan [PHASES];
    sample_t edge_words [8];

    tracker      = new();
    calm         = 1'b0;
    gap_pct      = 20;
    stall_pct    = 20;
    gap_cycles   = 0;
    stall_cycles = 0;
    sent         = 0;
    settings     = 0;
    cluster_base = sample_t'($urandom);
    ramp_pos     = sample_t'($urandom);
    ramp_step    = sample_t'($urandom_range(300));

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset window of 5. Extremes, alternating bit patterns, and the
    // even-count average whose sum needs the 17th bit (FFFF + FFFE).
    edge_words = '{16'hFFFF, 16'hFFFE, 16'h0000, 16'hAAAA,
                   16'h5555, 16'h0001, 16'h8000, 16'h7FFF};
    foreach (edge_words[i]) push_sample(edge_words[i]);

    // Window size zero behaves as a window of one: output follows input.
    write_window(cfg_t'(0));
    push_sample(16'hFFFF);
    push_sample(16'h1234);
    push_sample(16'h0000);

    // Above the chain length behaves as the full chain; ten descending values
    // from FFFF keep the even-count averages in the carry range.
    write_window(cfg_t'(17));
    for (int i = 0; i < 10; i++)
      push_sample(sample_t'(16'hFFFF - i * 4099));

    // Random phases over the register extremes and a few random settings.
    window_plan = '{cfg_t'(1), cfg_t'(16), cfg_t'(0), cfg_t'(31), cfg_t'(2),
                    cfg_t'(8), cfg_t'(17), cfg_t'($urandom_range(31)),
                    cfg_t'($urandom_range(31)), cfg_t'(CFG_RESET)};
    for (int p = 0; p < PHASES; p++) begin
      write_window(window_plan[p]);
      // Every third phase has no input gaps, the next no output stalls; the last has no idling.
      gap_pct      = (p % 3 == 0) ? 0 : $urandom_range(4) * 10;
      stall_pct    = (p % 3 == 1) ? 0 : $urandom_range(4) * 10;
      calm         = (p == PHASES - 1);
      cluster_base = sample_t'($urandom);
      ramp_step    = sample_t'($urandom_range(1) ? $urandom_range(500)
                                                 : 32'h10000 - $urandom_range(500));
      for (int k = 0; k < PHASE_WORDS; k++)
        push_sample(draw_sample());
    end

    // All stimulus accepted: wait for the tail and a few quiet cycles in case
    // a stray median follows.
    sample_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);

    $display("coverage: %0d samples over %0d window_size writes (0, 1, 2, 8, 16, 17, 31, 5)",
             sent, settings);
    $display("coverage: %0d medians compared, %0d input gap cycles, %0d output stall cycles",
             tracker.checked, gap_cycles, stall_cycles);
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d medians outstanding", tracker.failures,
               tracker.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
